>>> src/swik_pkg.sv
// ----------------------------------------------------------------------------
// swik_pkg: shared types and constants for swerve inverse kinematics
// Payload structs, controller commands, fixed-point widths and tables.
// ----------------------------------------------------------------------------
package swik_pkg;

    localparam int MODULE_COUNT = 4;
    localparam int CORDIC_STEPS = 14;

    // Field and datapath widths
    localparam int DATA_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W   = 5;
    localparam int VEL_W    = 21;
    localparam int XY_W     = 26;
    localparam int Z_W      = 21;
    localparam int SPD_W    = 24;
    localparam int ANG_W    = 17;
    localparam int MUL_A_W  = 27;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Fixed-point constants
    localparam logic signed [Z_W-1:0]     PI_Q16        = Z_W'(205887);
    localparam logic signed [ANG_W-1:0]   PI_Q12        = ANG_W'(12868);
    localparam logic signed [ANG_W-1:0]   HALF_PI_Q12   = ANG_W'(6434);
    localparam logic [DATA_W-1:0]         GAIN_COMP_Q16 = DATA_W'(39797);
    localparam logic signed [PROD_W-1:0]  RPM_LIMIT     = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0]  RPM_ROUND     = PROD_W'(64'd1 << 23);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LINEAR_SPEED = 3'd0,
        CFG_MAX_TURN_RATE    = 3'd1,
        CFG_HALF_WHEEL_BASE  = 3'd2,
        CFG_HALF_TRACK_WIDTH = 3'd3,
        CFG_RPM_GAIN         = 3'd4
    } cfg_idx_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_VX,
        OP_VY,
        OP_W,
        OP_ROT_B,
        OP_ROT_T,
        OP_SETUP,
        OP_ITER,
        OP_MAG,
        OP_RPM,
        OP_FINAL
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       slot;
        logic [STEP_W-1:0] step;
    } ctl_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cmd_x;
        logic signed [DATA_W-1:0] cmd_y;
        logic signed [DATA_W-1:0] cmd_turn;
        logic signed [DATA_W-1:0] measured_angle_fl;
        logic signed [DATA_W-1:0] measured_angle_rl;
        logic signed [DATA_W-1:0] measured_angle_rr;
        logic signed [DATA_W-1:0] measured_angle_fr;
    } in_t;

    typedef struct packed {
        logic [1:0]               module_index;
        logic signed [DATA_W-1:0] steer_target;
        logic signed [DATA_W-1:0] drive_rpm;
        logic                     last_of_set;
    } out_t;

    // Rounded arctangent of 2^-i in Q.16
    function automatic logic [DATA_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [DATA_W-1:0] r;
        unique case (i)
            5'd0:    r = 16'd51472;
            5'd1:    r = 16'd30385;
            5'd2:    r = 16'd16055;
            5'd3:    r = 16'd8150;
            5'd4:    r = 16'd4091;
            5'd5:    r = 16'd2047;
            5'd6:    r = 16'd1024;
            5'd7:    r = 16'd512;
            5'd8:    r = 16'd256;
            5'd9:    r = 16'd128;
            5'd10:   r = 16'd64;
            5'd11:   r = 16'd32;
            5'd12:   r = 16'd16;
            5'd13:   r = 16'd8;
            5'd14:   r = 16'd4;
            5'd15:   r = 16'd2;
            5'd16:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Emission slot to module: FR, FL, RR, RL
    function automatic logic [1:0] emit_module(input logic [1:0] slot);
        logic [1:0] m;
        unique case (slot)
            2'd0:    m = 2'd3;
            2'd1:    m = 2'd0;
            2'd2:    m = 2'd2;
            default: m = 2'd1;
        endcase
        return m;
    endfunction

endpackage

>>> src/swik_ctrl.sv
// ----------------------------------------------------------------------------
// swik_ctrl: sequencer for swerve inverse kinematics
// Walks the scaling multiplies, then four CORDIC passes, one per module.
// ----------------------------------------------------------------------------
module swik_ctrl #(
    parameter int CORDIC_STEPS = swik_pkg::CORDIC_STEPS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  swik_pkg::sts_t sts,
    output swik_pkg::ctl_t ctl
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_VX    = 11'b00000000010,
        ST_VY    = 11'b00000000100,
        ST_W     = 11'b00000001000,
        ST_ROT_B = 11'b00000010000,
        ST_ROT_T = 11'b00000100000,
        ST_SETUP = 11'b00001000000,
        ST_ITER  = 11'b00010000000,
        ST_MAG   = 11'b00100000000,
        ST_RPM   = 11'b01000000000,
        ST_FINAL = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [1:0]       slot_reg, slot_next;
    swik_pkg::op_t    op;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        slot_next  = slot_reg;
        op         = swik_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op         = swik_pkg::OP_LOAD;
                    slot_next  = 2'd0;
                    state_next = ST_VX;
                end
            end
            ST_VX: begin
                op         = swik_pkg::OP_VX;
                state_next = ST_VY;
            end
            ST_VY: begin
                op         = swik_pkg::OP_VY;
                state_next = ST_W;
            end
            ST_W: begin
                op         = swik_pkg::OP_W;
                state_next = ST_ROT_B;
            end
            ST_ROT_B: begin
                op         = swik_pkg::OP_ROT_B;
                state_next = ST_ROT_T;
            end
            ST_ROT_T: begin
                op         = swik_pkg::OP_ROT_T;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                op         = swik_pkg::OP_SETUP;
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                op = swik_pkg::OP_ITER;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_MAG;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MAG: begin
                op         = swik_pkg::OP_MAG;
                state_next = ST_RPM;
            end
            ST_RPM: begin
                op         = swik_pkg::OP_RPM;
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                // hold until the output register can take the beat
                if (sts.out_free) begin
                    op = swik_pkg::OP_FINAL;
                    if (slot_reg == 2'(swik_pkg::MODULE_COUNT - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            slot_reg  <= slot_next;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign ctl.op   = op;
    assign ctl.slot = slot_reg;
    assign ctl.step = swik_pkg::STEP_W'(step_reg);

endmodule

>>> src/swik_dp.sv
// ----------------------------------------------------------------------------
// swik_dp: datapath for swerve inverse kinematics
// Shared multiplier, CORDIC vectoring unit, held angles and output register.
// ----------------------------------------------------------------------------
module swik_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  swik_pkg::ctl_t                        ctl,
    output swik_pkg::sts_t                        sts,
    input  swik_pkg::in_t                         s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output swik_pkg::out_t                        m_data,
    input  logic                                  cfg_we,
    input  logic [swik_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swik_pkg::DATA_W-1:0]           cfg_wdata
);

    localparam int DW = swik_pkg::DATA_W;
    localparam int VW = swik_pkg::VEL_W;
    localparam int XW = swik_pkg::XY_W;
    localparam int ZW = swik_pkg::Z_W;
    localparam int SW = swik_pkg::SPD_W;
    localparam int AW = swik_pkg::ANG_W;
    localparam int PW = swik_pkg::PROD_W;

    // Configuration registers
    logic [DW-1:0] max_lin_reg, max_turn_reg, hwb_reg, htw_reg, rpm_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lin_reg  <= DW'(8192);
            max_turn_reg <= DW'(16384);
            hwb_reg      <= DW'(13107);
            htw_reg      <= DW'(13107);
            rpm_gain_reg <= DW'(48896);
        end else if (cfg_we) begin
            unique case (cfg_index)
                swik_pkg::CFG_MAX_LINEAR_SPEED: max_lin_reg  <= cfg_wdata;
                swik_pkg::CFG_MAX_TURN_RATE:    max_turn_reg <= cfg_wdata;
                swik_pkg::CFG_HALF_WHEEL_BASE:  hwb_reg      <= cfg_wdata;
                swik_pkg::CFG_HALF_TRACK_WIDTH: htw_reg      <= cfg_wdata;
                swik_pkg::CFG_RPM_GAIN:         rpm_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    swik_pkg::in_t         in_reg;
    logic signed [VW-1:0]  vx_reg, vy_reg, w_reg, rot_b_reg, rot_t_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic signed [SW-1:0]  speed_reg;
    logic signed [DW-1:0]  angle_reg;
    logic signed [DW-1:0]  rpm_reg;
    logic signed [DW-1:0]  held_reg [swik_pkg::MODULE_COUNT];
    logic                  m_valid_reg;
    swik_pkg::out_t        m_data_reg;

    logic [1:0] mod_sel;
    assign mod_sel = swik_pkg::emit_module(ctl.slot);

    // Shared multiplier operand selection
    logic signed [swik_pkg::MUL_A_W-1:0] mul_a;
    logic [DW-1:0]                       mul_b_u;
    logic signed [PW-1:0]                prod;

    always_comb begin
        mul_a   = '0;
        mul_b_u = '0;
        unique case (ctl.op)
            swik_pkg::OP_VX: begin
                mul_a = swik_pkg::MUL_A_W'(in_reg.cmd_x);     mul_b_u = max_lin_reg;
            end
            swik_pkg::OP_VY: begin
                mul_a = swik_pkg::MUL_A_W'(in_reg.cmd_y);     mul_b_u = max_lin_reg;
            end
            swik_pkg::OP_W: begin
                mul_a = swik_pkg::MUL_A_W'(in_reg.cmd_turn);  mul_b_u = max_turn_reg;
            end
            swik_pkg::OP_ROT_B: begin
                mul_a = swik_pkg::MUL_A_W'(w_reg);            mul_b_u = hwb_reg;
            end
            swik_pkg::OP_ROT_T: begin
                mul_a = swik_pkg::MUL_A_W'(w_reg);            mul_b_u = htw_reg;
            end
            swik_pkg::OP_MAG: begin
                mul_a = swik_pkg::MUL_A_W'(x_reg);  mul_b_u = swik_pkg::GAIN_COMP_Q16;
            end
            swik_pkg::OP_RPM: begin
                mul_a = swik_pkg::MUL_A_W'(speed_reg);        mul_b_u = rpm_gain_reg;
            end
            default: ;
        endcase
    end

    assign prod = PW'(mul_a) * PW'($signed({1'b0, mul_b_u}));

    // Per-module vector setup and CORDIC step
    logic signed [XW-1:0] xc, yc, dx, dy;
    logic signed [ZW-1:0] atan_val;
    logic signed [ZW-1:0] ang_q12_wide;
    logic signed [SW-1:0] speed_new;
    logic signed [PW-1:0] rpm_wide;

    assign yc = mod_sel[1] ? XW'(vy_reg) + XW'(rot_b_reg) : XW'(vy_reg) - XW'(rot_b_reg);
    assign xc = (mod_sel == 2'd1 || mod_sel == 2'd2)
              ? XW'(vx_reg) + XW'(rot_t_reg) : XW'(vx_reg) - XW'(rot_t_reg);
    assign dx = y_reg >>> ctl.step;
    assign dy = x_reg >>> ctl.step;
    assign atan_val = ZW'($signed({1'b0, swik_pkg::atan_q16(ctl.step)}));
    assign ang_q12_wide = (z_reg + ZW'(8)) >>> 4;
    assign speed_new = SW'(prod >>> 16);
    assign rpm_wide = (prod + swik_pkg::RPM_ROUND) >>> 24;

    // Angle optimisation against the measured angle
    logic signed [DW-1:0] meas;
    logic signed [AW-1:0] delta, target;
    logic                 flip;

    always_comb begin
        unique case (mod_sel)
            2'd0:    meas = in_reg.measured_angle_fl;
            2'd1:    meas = in_reg.measured_angle_rl;
            2'd2:    meas = in_reg.measured_angle_rr;
            default: meas = in_reg.measured_angle_fr;
        endcase
    end

    assign delta = AW'(angle_reg) - AW'(meas);
    assign flip  = (delta > swik_pkg::HALF_PI_Q12) || (delta < -swik_pkg::HALF_PI_Q12);
    assign target = !flip ? AW'(angle_reg)
                  : (delta > 0) ? AW'(angle_reg) - swik_pkg::PI_Q12
                  : AW'(angle_reg) + swik_pkg::PI_Q12;

    // Working registers
    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            swik_pkg::OP_LOAD:  in_reg    <= s_data;
            swik_pkg::OP_VX:    vx_reg    <= VW'(prod >>> 11);
            swik_pkg::OP_VY:    vy_reg    <= VW'(prod >>> 11);
            swik_pkg::OP_W:     w_reg     <= VW'(prod >>> 11);
            swik_pkg::OP_ROT_B: rot_b_reg <= VW'(prod >>> 16);
            swik_pkg::OP_ROT_T: rot_t_reg <= VW'(prod >>> 16);
            swik_pkg::OP_SETUP: begin
                // fold left half-plane vectors over, starting at +/- pi
                if (xc < 0) begin
                    x_reg <= -xc;
                    y_reg <= -yc;
                    z_reg <= (yc >= 0) ? swik_pkg::PI_Q16 : -swik_pkg::PI_Q16;
                end else begin
                    x_reg <= xc;
                    y_reg <= yc;
                    z_reg <= '0;
                end
            end
            swik_pkg::OP_ITER: begin
                if (y_reg < 0) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_val;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_val;
                end
            end
            swik_pkg::OP_MAG: begin
                if (speed_new > 0) begin
                    speed_reg <= speed_new;
                    angle_reg <= DW'(ang_q12_wide);
                end else begin
                    speed_reg <= '0;
                    angle_reg <= held_reg[mod_sel];
                end
            end
            swik_pkg::OP_RPM: begin
                rpm_reg <= (rpm_wide > swik_pkg::RPM_LIMIT) ? DW'(swik_pkg::RPM_LIMIT)
                                                            : DW'(rpm_wide);
            end
            default: ;
        endcase
    end

    // Held steering angle per module, updated only on positive speed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < swik_pkg::MODULE_COUNT; i++) begin
                held_reg[i] <= '0;
            end
        end else if (ctl.op == swik_pkg::OP_MAG && speed_new > 0) begin
            held_reg[mod_sel] <= DW'(ang_q12_wide);
        end
    end

    // Output register: load a beat, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.op == swik_pkg::OP_FINAL) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == swik_pkg::OP_FINAL) begin
            m_data_reg.module_index <= mod_sel;
            m_data_reg.steer_target <= DW'(target);
            m_data_reg.drive_rpm    <= flip ? -rpm_reg : rpm_reg;
            m_data_reg.last_of_set  <= (ctl.slot == 2'(swik_pkg::MODULE_COUNT - 1));
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

>>> src/swerve_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics: four-module swerve drive inverse kinematics
// Scales chassis commands, resolves each wheel vector by CORDIC and
// optimises the steering target against the measured angle.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         cmd_x, cmd_y, cmd_turn, four measured angles
//  m_*       out        module_index, steer_target, drive_rpm, last_of_set
//  cfg_*     in         write of one of five configuration registers
//
//  Each command runs five scaling multiplies on the shared multiplier,
//  then per module one setup, CORDIC_STEPS iterations of the CORDIC
//  unit, two multiplies and a final step. Four beats leave per command,
//  FR, FL, RR, RL.
//  A stalled output holds the sequencer at its final step.
//  Reset is synchronous; held angles clear to zero at reset.
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics #(
    parameter int CORDIC_STEPS = swik_pkg::CORDIC_STEPS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  swik_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output swik_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [swik_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swik_pkg::DATA_W-1:0]     cfg_wdata
);

    swik_pkg::ctl_t ctl;
    swik_pkg::sts_t sts;

    // Sequencer
    swik_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // Arithmetic and storage
    swik_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
